>>> sv/lpm_pkg.sv
// Shared types, constants and helpers for the IPv4 longest-prefix-match unit.
`timescale 1ns / 1ps

package lpm_pkg;

	// Table geometry and field widths
	localparam int TABLE_ENTRIES = 64;
	localparam int ADDR_W        = 32;
	localparam int LEN_W         = 6;
	localparam int TAG_W         = 16;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

	// Request kinds carried on s_tuser
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	// Result status carried on m_tuser
	typedef enum logic [1:0] {
		ST_STORED = 2'd0,
		ST_FULL   = 2'd1,
		ST_HIT    = 2'd2,
		ST_MISS   = 2'd3
	} status_t;

	// Control sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	// One stored route
	typedef struct packed {
		logic [ADDR_W-1:0] prefix;
		logic [LEN_W-1:0]  len;
		logic [TAG_W-1:0]  tag;
	} route_entry_t;

	// Access request to the route table
	typedef struct packed {
		logic               rd_en;
		logic [IDX_W-1:0]   rd_addr;
		logic               wr_en;
		logic [IDX_W-1:0]   wr_addr;
		route_entry_t       wr_data;
	} tbl_req_t;

	// Mask that keeps the top len bits of an address
	function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
		prefix_mask = ~({ADDR_W{1'b1}} >> len);
	endfunction

endpackage

>>> sv/ipv4_longest_prefix_match_unit.sv
// IPv4 longest-prefix-match unit: one request in, one result out, routes kept in a table memory.
// Each request scans the stored routes through the table's single read port, one entry per
// cycle. An item passes through these steps in order: the accept cycle, the issued reads and
// the return of the last read data (neither on an empty table), the exit from the scan, and
// the finishing cycle, which is held as long as the previous result is still waiting to
// be taken. An insert updates the tag of an identical prefix in place or appends a new
// route; a 65th distinct prefix is refused with status "table full". A lookup returns the
// tag and length of the longest stored prefix covering the address, or a miss. The result
// waits in an output register, so the next request is taken while it is still unread.
`timescale 1ns / 1ps

module ipv4_longest_prefix_match_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Request side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // [31:0] address, [37:32] prefix_len, [53:38] route_tag, pad
	input  logic        s_tuser,  // [0] req_type
	// Result side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [15:0] result_tag, [21:16] match_len, pad
	output logic [1:0]  m_tuser   // [1:0] status
);
	import lpm_pkg::*;

	state_t              state_q, state_d;
	tbl_req_t            tbl_req;
	route_entry_t        rd_data;

	logic                req_q;
	logic [ADDR_W-1:0]   key_q;
	logic [LEN_W-1:0]    len_q;
	logic [TAG_W-1:0]    tag_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    issue_q;
	logic                rd_vld_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic                hit_q;
	logic [IDX_W-1:0]    hit_idx_q;
	logic [LEN_W-1:0]    best_len_q;
	logic [TAG_W-1:0]    best_tag_q;

	logic                m_tvalid_q;
	status_t             m_status_q;
	logic [TAG_W-1:0]    m_tag_q;
	logic [LEN_W-1:0]    m_len_q;

	logic                in_acc;
	logic                out_free;
	logic                finish;
	logic                entry_match;
	logic [LEN_W-1:0]    in_len;
	logic [LEN_W-1:0]    len_c;
	logic                tbl_full;

	// Request fields with insert length saturated to 1..ADDR_W
	assign in_len   = s_tdata[37:32];
	assign len_c    = (in_len == '0) ? LEN_W'(1)
	                : ((in_len > LEN_W'(ADDR_W)) ? LEN_W'(ADDR_W) : in_len);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign tbl_full = (count_q == CNT_W'(TABLE_ENTRIES));

	// Compare of the entry returned by the table
	always_comb begin
		if (req_q == REQ_LOOKUP) begin
			entry_match = ((key_q & prefix_mask(rd_data.len)) == rd_data.prefix)
			              && (!hit_q || (rd_data.len > best_len_q));
		end else begin
			entry_match = (rd_data.len == len_q) && (rd_data.prefix == key_q);
		end
	end

	// Next state, table requests, handshake
	always_comb begin
		state_d         = state_q;
		s_tready        = 1'b0;
		finish          = 1'b0;
		tbl_req         = '0;
		tbl_req.rd_addr = issue_q[IDX_W-1:0];
		tbl_req.wr_data = '{prefix: key_q, len: len_q, tag: tag_q};
		tbl_req.wr_addr = hit_q ? hit_idx_q : count_q[IDX_W-1:0];
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				tbl_req.rd_en = (issue_q < count_q);
				if (!tbl_req.rd_en && !rd_vld_s1) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					finish        = 1'b1;
					tbl_req.wr_en = (req_q == REQ_INSERT) && (hit_q || !tbl_full);
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q <= s_tuser;
			len_q <= len_c;
			tag_q <= s_tdata[53:38];
			key_q <= (s_tuser == REQ_LOOKUP) ? s_tdata[31:0]
			       : (s_tdata[31:0] & prefix_mask(len_c));
		end
	end

	// Scan control and route count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			issue_q   <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
		end else begin
			rd_vld_s1 <= tbl_req.rd_en;
			if (in_acc) begin
				issue_q <= '0;
				hit_q   <= 1'b0;
			end else if (tbl_req.rd_en) begin
				issue_q <= issue_q + CNT_W'(1);
			end
			if (rd_vld_s1 && entry_match) begin
				hit_q <= 1'b1;
			end
			if (finish && tbl_req.wr_en && !hit_q) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// Best match so far
	always_ff @(posedge clk) begin
		idx_s1 <= issue_q[IDX_W-1:0];
		if (rd_vld_s1 && entry_match) begin
			hit_idx_q  <= idx_s1;
			best_len_q <= rd_data.len;
			best_tag_q <= rd_data.tag;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			if (req_q == REQ_LOOKUP) begin
				m_status_q <= hit_q ? ST_HIT : ST_MISS;
				m_tag_q    <= hit_q ? best_tag_q : '0;
				m_len_q    <= hit_q ? best_len_q : '0;
			end else begin
				m_status_q <= (hit_q || !tbl_full) ? ST_STORED : ST_FULL;
				m_tag_q    <= '0;
				m_len_q    <= '0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {2'b00, m_len_q, m_tag_q};

	lpm_table u_table (
		.clk     (clk),
		.req     (tbl_req),
		.rd_data (rd_data)
	);

	// Route count never exceeds the table
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_ENTRIES))
		else $error("route count beyond table size");

	// Route count only grows, one route at a time
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("route count moved by other than one");

	// Table read data only returns while scanning
	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == S_SCAN))
		else $error("table read outside scan");

	// A new result only appears after the finishing state
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> ($past(state_q) == S_DONE))
		else $error("result without finished request");

endmodule

>>> sv/lpm_table.sv
// Route table storage: single-port-write, registered-read memory.
`timescale 1ns / 1ps

module lpm_table (
	input  logic                  clk,
	input  lpm_pkg::tbl_req_t     req,
	output lpm_pkg::route_entry_t rd_data
);
	import lpm_pkg::*;

	route_entry_t mem [TABLE_ENTRIES];

	// Write port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	// Read port, registered output
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule
